>>> design/keyword_delimiter_tokenizer_core_defines.svh
// Assertion macros shared by the tokenizer core.
`ifndef KEYWORD_DELIMITER_TOKENIZER_CORE_DEFINES_SVH
`define KEYWORD_DELIMITER_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define KDT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyword_delimiter_tokenizer_core: check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define KDT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyword_delimiter_tokenizer_core: check failed");

`endif

>>> design/kdt_pkg.sv
// Types, constants and lookup functions of the keyword and delimiter tokenizer.
package kdt_pkg;

  localparam int HOPPER_DEPTH = 32;
  localparam int CNT_W        = $clog2(HOPPER_DEPTH + 1);
  localparam int ADDR_W       = $clog2(HOPPER_DEPTH);
  localparam int NUM_KW       = 3;
  localparam int KW_IDX_W     = 2;

  localparam logic       KIND_TEXT        = 1'b0;
  localparam logic       KIND_TOKEN       = 1'b1;
  localparam logic [7:0] TOKEN_WORD       = 8'd0;
  localparam logic [7:0] TOKEN_DELIM_BASE = 8'd2;
  localparam logic [7:0] TOKEN_KW_BASE    = 8'd10;
  localparam logic [7:0] NEWLINE_BYTE     = 8'd10;

  // keyword lengths: print, if, goto
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd5, 3'd2, 3'd4};

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } char_word_t;

  typedef struct packed {
    logic       stream_kind;
    logic [7:0] out_value;
    logic       last_of_run;
    logic       overflow_flag;
  } tok_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_FLUSH,
    S_NL,
    S_TOK,
    S_DELIM
  } kdt_state_t;

  // {hit, index in the delimiter set}
  function automatic logic [3:0] delim_lookup(input logic [7:0] c);
    case (c)
      8'h20:   return {1'b1, 3'd0}; // space
      8'h28:   return {1'b1, 3'd1}; // (
      8'h29:   return {1'b1, 3'd2}; // )
      8'h7B:   return {1'b1, 3'd3}; // {
      8'h7D:   return {1'b1, 3'd4}; // }
      8'h2B:   return {1'b1, 3'd5}; // +
      8'h2D:   return {1'b1, 3'd6}; // -
      8'h3D:   return {1'b1, 3'd7}; // =
      default: return 4'b0000;
    endcase
  endfunction

  // character pos of keyword k; only read below the keyword length
  function automatic logic [7:0] kw_char(input logic [KW_IDX_W-1:0] k,
                                         input logic [2:0] pos);
    case ({k, pos})
      5'b00_000: return 8'h70; // p
      5'b00_001: return 8'h72; // r
      5'b00_010: return 8'h69; // i
      5'b00_011: return 8'h6E; // n
      5'b00_100: return 8'h74; // t
      5'b01_000: return 8'h69; // i
      5'b01_001: return 8'h66; // f
      5'b10_000: return 8'h67; // g
      5'b10_001: return 8'h6F; // o
      5'b10_010: return 8'h74; // t
      5'b10_011: return 8'h6F; // o
      default:   return 8'h00;
    endcase
  endfunction

endpackage

>>> design/kdt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module kdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/keyword_delimiter_tokenizer_core.sv
// Keyword and delimiter tokenizer: hopper RAM, keyword tracking and output control.
// Sequence: a word is taken in S_IDLE and evaluated in S_EVAL; a keyword or drop result is
//   registered at the end of S_EVAL, a delimiter or flush result in S_DELIM or S_FLUSH.
// Words are taken only in S_IDLE, output states hold on stalls; plain, keyword and dropped
//   characters pass S_EVAL, a delimiter adds S_DELIM, a flush S_FLUSH per byte, S_NL, S_TOK.
// Reset (rst, synchronous): empties the hopper and the output register; RAM untouched.
`include "keyword_delimiter_tokenizer_core_defines.svh"

module keyword_delimiter_tokenizer_core
  import kdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  char_word_t char_word,
  output logic       tok_valid,
  input  logic       tok_stall,
  output tok_word_t  tok_word
);

  kdt_state_t state, state_next;

  // hopper fill level and per-keyword "still a prefix" flags
  logic [CNT_W-1:0]  hop_cnt;
  logic [NUM_KW-1:0] kw_ok;

  // latched item under evaluation
  logic [7:0] cur_char;
  logic       cur_end;
  logic       cur_is_delim;
  logic [2:0] cur_didx;

  // next hopper address to read during a flush
  logic [CNT_W-1:0] flush_ptr;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic      out_free, out_load;
  tok_word_t out_next;

  logic cnt_clear, cnt_inc, ptr_start, ptr_inc;

  logic [CNT_W-1:0]    cnt_plus;
  logic [NUM_KW-1:0]   kw_ok_next, kw_hit;
  logic [KW_IDX_W-1:0] hit_idx;
  logic                cnt_zero, cnt_full, any_hit, is_append;
  logic [3:0]          delim_in;

  assign char_stall = (state != S_IDLE);
  assign out_free   = !tok_valid || !tok_stall;
  assign cnt_plus   = hop_cnt + 1'b1;
  assign cnt_zero   = (hop_cnt == '0);
  assign cnt_full   = (hop_cnt == CNT_W'(HOPPER_DEPTH));
  assign delim_in   = delim_lookup(char_word.char_code);
  assign is_append  = !cur_end && !cur_is_delim && !cnt_full;

  // Incremental keyword match: a keyword stays live while every appended
  // byte equals its character at that position.
  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      kw_ok_next[k] = kw_ok[k] && (hop_cnt < CNT_W'(KW_LEN[k])) &&
                      (cur_char == kw_char(KW_IDX_W'(k), hop_cnt[2:0]));
      kw_hit[k]     = kw_ok_next[k] && (cnt_plus == CNT_W'(KW_LEN[k]));
    end
    hit_idx = '0;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (kw_hit[k]) begin
        hit_idx = KW_IDX_W'(k);
      end
    end
  end

  assign any_hit = |kw_hit;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (char_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (cur_end) begin
          state_next = cnt_zero ? S_IDLE : S_FLUSH;
        end else if (cur_is_delim) begin
          state_next = cnt_zero ? S_DELIM : S_FLUSH;
        end else if (cnt_full || any_hit) begin
          if (out_free) begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (out_free && flush_ptr == hop_cnt) begin
          state_next = S_NL;
        end
      end
      S_NL: begin
        if (out_free) begin
          state_next = S_TOK;
        end
      end
      S_TOK: begin
        if (out_free) begin
          state_next = cur_end ? S_IDLE : S_DELIM;
        end
      end
      S_DELIM: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: RAM access, output register load, counter control.
  always_comb begin
    out_load  = 1'b0;
    out_next  = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = flush_ptr[ADDR_W-1:0];
    cnt_clear = 1'b0;
    cnt_inc   = 1'b0;
    ptr_start = 1'b0;
    ptr_inc   = 1'b0;
    case (state)
      S_EVAL: begin
        if ((cur_end || cur_is_delim) && !cnt_zero) begin
          // prime the first hopper byte
          ram_re    = 1'b1;
          ram_raddr = '0;
          ptr_start = 1'b1;
        end else if (!cur_end && !cur_is_delim && cnt_full) begin
          if (out_free) begin
            out_load = 1'b1;
            out_next = '{KIND_TEXT, cur_char, 1'b1, 1'b1};
          end
        end else if (is_append && (!any_hit || out_free)) begin
          ram_we = 1'b1;
          if (any_hit) begin
            out_load  = 1'b1;
            out_next  = '{KIND_TOKEN, TOKEN_KW_BASE + 8'(hit_idx), 1'b1, 1'b0};
            cnt_clear = 1'b1;
          end else begin
            cnt_inc = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          out_next = '{KIND_TEXT, ram_rdata, 1'b0, 1'b0};
          if (flush_ptr != hop_cnt) begin
            ram_re  = 1'b1;
            ptr_inc = 1'b1;
          end
        end
      end
      S_NL: begin
        if (out_free) begin
          out_load = 1'b1;
          out_next = '{KIND_TEXT, NEWLINE_BYTE, 1'b0, 1'b0};
        end
      end
      S_TOK: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_next  = '{KIND_TOKEN, TOKEN_WORD, cur_end, 1'b0};
          cnt_clear = 1'b1;
        end
      end
      S_DELIM: begin
        if (out_free) begin
          out_load = 1'b1;
          out_next = '{KIND_TOKEN, TOKEN_DELIM_BASE + 8'(cur_didx), 1'b1, 1'b0};
        end
      end
      default: ;
    endcase
  end

  kdt_ram #(
    .WIDTH (8),
    .DEPTH (HOPPER_DEPTH)
  ) u_hopper (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hop_cnt[ADDR_W-1:0]),
    .wdata (cur_char),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hop_cnt   <= '0;
      kw_ok     <= '1;
      tok_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cnt_clear) begin
        hop_cnt <= '0;
        kw_ok   <= '1;
      end else if (cnt_inc) begin
        hop_cnt <= cnt_plus;
        kw_ok   <= kw_ok_next;
      end
      if (out_load) begin
        tok_valid <= 1'b1;
      end else if (!tok_stall) begin
        tok_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      cur_char     <= char_word.char_code;
      cur_end      <= char_word.end_of_text;
      cur_is_delim <= delim_in[3];
      cur_didx     <= delim_in[2:0];
    end
    if (ptr_start) begin
      flush_ptr <= CNT_W'(1);
    end else if (ptr_inc) begin
      flush_ptr <= flush_ptr + 1'b1;
    end
    if (out_load) begin
      tok_word <= out_next;
    end
  end

  `KDT_ASSERT_NOW(a_cnt_range, 1'b1, hop_cnt <= CNT_W'(HOPPER_DEPTH))
  `KDT_ASSERT_NOW(a_load_free, out_load, !tok_valid || !tok_stall)
  `KDT_ASSERT_NEXT(a_accept_eval, char_valid && !char_stall, state == S_EVAL)
  `KDT_ASSERT_NOW(a_flush_ptr, state == S_FLUSH, flush_ptr <= hop_cnt && !cnt_zero)

endmodule

>>> dv/keyword_delimiter_tokenizer_core_tb.sv
// Self-checking testbench of the keyword and delimiter tokenizer core.
module keyword_delimiter_tokenizer_core_tb
  import kdt_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int RANDOM_ITEMS   = 85;
  localparam int HOLD_CYCLES    = 160;
  localparam int N_DIRECTED     = 25;

  localparam logic [7:0] DELIMS [8] = '{8'h20, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2B, 8'h2D, 8'h3D};

  // One stimulus word; when typed is set, exp is the single result it must cause.
  typedef struct packed {
    char_word_t w;
    logic       typed;
    tok_word_t  exp;
  } stim_item_t;

  // code, end_of_text, typed, {kind, value, last, overflow}
  localparam stim_item_t DIRECTED [N_DIRECTED] = '{
    {8'h20, 1'b1, 1'b0, 11'd0},                           // end with empty hopper, char ignored
    {8'h20, 1'b0, 1'b1, KIND_TOKEN, 8'd2,  1'b1, 1'b0},   // space
    {8'h28, 1'b0, 1'b1, KIND_TOKEN, 8'd3,  1'b1, 1'b0},   // (
    {8'h29, 1'b0, 1'b1, KIND_TOKEN, 8'd4,  1'b1, 1'b0},   // )
    {8'h7B, 1'b0, 1'b1, KIND_TOKEN, 8'd5,  1'b1, 1'b0},   // {
    {8'h7D, 1'b0, 1'b1, KIND_TOKEN, 8'd6,  1'b1, 1'b0},   // }
    {8'h2B, 1'b0, 1'b1, KIND_TOKEN, 8'd7,  1'b1, 1'b0},   // +
    {8'h2D, 1'b0, 1'b1, KIND_TOKEN, 8'd8,  1'b1, 1'b0},   // -
    {8'h3D, 1'b0, 1'b1, KIND_TOKEN, 8'd9,  1'b1, 1'b0},   // =
    {8'h69, 1'b0, 1'b0, 11'd0},                           // i
    {8'h66, 1'b0, 1'b1, KIND_TOKEN, 8'd11, 1'b1, 1'b0},   // f -> if
    {8'h67, 1'b0, 1'b0, 11'd0},                           // g
    {8'h6F, 1'b0, 1'b0, 11'd0},                           // o
    {8'h74, 1'b0, 1'b0, 11'd0},                           // t
    {8'h6F, 1'b0, 1'b1, KIND_TOKEN, 8'd12, 1'b1, 1'b0},   // o -> goto
    {8'h70, 1'b0, 1'b0, 11'd0},                           // p
    {8'h72, 1'b0, 1'b0, 11'd0},                           // r
    {8'h69, 1'b0, 1'b0, 11'd0},                           // i
    {8'h6E, 1'b0, 1'b0, 11'd0},                           // n
    {8'h74, 1'b0, 1'b1, KIND_TOKEN, 8'd10, 1'b1, 1'b0},   // t -> print
    {8'h00, 1'b0, 1'b0, 11'd0},                           // zero byte is plain text
    {8'hFF, 1'b0, 1'b0, 11'd0},
    {8'h3D, 1'b0, 1'b0, 11'd0},                           // flush of two bytes, then =
    {8'h7A, 1'b0, 1'b0, 11'd0},
    {8'h28, 1'b1, 1'b0, 11'd0}                            // end flushes, ( not a delimiter here
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       char_valid;
  logic       char_stall;
  char_word_t char_word;
  logic       tok_valid;
  logic       tok_stall;
  tok_word_t  tok_word;

  keyword_delimiter_tokenizer_core dut (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_word (char_word),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_word  (tok_word)
  );

  always #5 clk = ~clk;

  stim_item_t stim_q [$];
  stim_item_t cur_item;
  tok_word_t  token_q [$];   // expected output words, oldest first
  tok_word_t  run_q [$];     // results of the character under evaluation
  tok_word_t  want;

  // lexer shadow state
  logic [7:0] hop [HOPPER_DEPTH];
  int         hop_n = 0;
  string      KWORDS [3] = '{"print", "if", "goto"};

  int  n_taken = 0;
  int  n_total = 0;
  int  n_checked = 0;
  int  n_fail = 0;
  int  n_flush = 0;
  int  n_kw = 0;
  int  n_drop = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  logic calm;

  // stretch with no idling on either side
  assign calm = (n_taken >= 70) && (n_taken < 100);

  function automatic int delim_index(input logic [7:0] c);
    for (int i = 0; i < 8; i++)
      if (DELIMS[i] == c) return i;
    return -1;
  endfunction

  function automatic int keyword_hit();
    bit same;
    for (int k = 0; k < 3; k++) begin
      if (hop_n == KWORDS[k].len()) begin
        same = 1;
        for (int i = 0; i < hop_n; i++)
          if (hop[i] != KWORDS[k][i]) same = 0;
        if (same) return k;
      end
    end
    return -1;
  endfunction

  task automatic flush_hopper();
    if (hop_n != 0) begin
      for (int i = 0; i < hop_n; i++)
        run_q.push_back({KIND_TEXT, hop[i], 1'b0, 1'b0});
      run_q.push_back({KIND_TEXT, NEWLINE_BYTE, 1'b0, 1'b0});
      run_q.push_back({KIND_TOKEN, TOKEN_WORD, 1'b0, 1'b0});
      hop_n = 0;
      n_flush++;
    end
  endtask

  // Works out the output words that one input word causes.
  task automatic lex_char(input char_word_t w);
    int d;
    int k;
    tok_word_t t;
    run_q.delete();
    if (w.end_of_text) begin
      flush_hopper();
    end else begin
      d = delim_index(w.char_code);
      if (d >= 0) begin
        flush_hopper();
        run_q.push_back({KIND_TOKEN, TOKEN_DELIM_BASE + 8'(d), 1'b0, 1'b0});
      end else if (hop_n >= HOPPER_DEPTH) begin
        run_q.push_back({KIND_TEXT, w.char_code, 1'b0, 1'b1});
        n_drop++;
      end else begin
        hop[hop_n] = w.char_code;
        hop_n++;
        k = keyword_hit();
        if (k >= 0) begin
          run_q.push_back({KIND_TOKEN, TOKEN_KW_BASE + 8'(k), 1'b0, 1'b0});
          hop_n = 0;
          n_kw++;
        end
      end
    end
    if (run_q.size() > 0) begin
      t = run_q.pop_back();
      t.last_of_run = 1'b1;
      run_q.push_back(t);
    end
  endtask

  task automatic add_char(input logic [7:0] c, input logic eot);
    stim_q.push_back({c, eot, 1'b0, 11'd0});
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (delim_index(c) >= 0);
    return c;
  endfunction

  task automatic add_letters(input int len);
    for (int i = 0; i < len; i++)
      add_char(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
  endtask

  // Random text: keywords and near misses, words, raw bytes, hopper overflow, noise.
  task automatic build_random();
    int k;
    int n;
    int base;
    base = stim_q.size();
    // open with an overflowing word so the hopper fills early
    for (int i = 0; i < HOPPER_DEPTH + 2; i++) add_char(plain_byte(), 1'b0);
    add_char(DELIMS[$urandom_range(0, 7)], 1'b0);
    while (stim_q.size() - base < RANDOM_ITEMS) begin
      case ($urandom_range(0, 11))
        0, 1: begin
          k = $urandom_range(0, 2);
          n = $urandom_range(0, 3);
          if (n == 0) add_letters(1);
          for (int i = 0; i < KWORDS[k].len() - (n == 1 ? 1 : 0); i++)
            add_char(KWORDS[k][i], 1'b0);
          if ($urandom_range(0, 1)) add_char(DELIMS[$urandom_range(0, 7)], 1'b0);
        end
        2, 3, 4: begin
          add_letters($urandom_range(1, 8));
          add_char(DELIMS[$urandom_range(0, 7)], 1'b0);
        end
        5: begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) add_char(plain_byte(), 1'b0);
          add_char(8'($urandom_range(0, 255)), 1'b1);
        end
        6: add_char(DELIMS[$urandom_range(0, 7)], 1'b0);
        7: add_char(8'($urandom_range(0, 255)), 1'b1);
        8: begin
          add_letters($urandom_range(HOPPER_DEPTH - 2, HOPPER_DEPTH + 4));
          add_char(DELIMS[$urandom_range(0, 7)], 1'b0);
        end
        default: add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  // Sender: a stalled word holds; a new word is offered or the line idles.
  always @(posedge clk) begin
    if (!rst) begin
      if (char_valid && !char_stall) begin
        lex_char(cur_item.w);
        if (cur_item.typed) token_q.push_back(cur_item.exp);
        else foreach (run_q[i]) token_q.push_back(run_q[i]);
        n_taken <= n_taken + 1;
      end
      if (!char_valid || !char_stall) begin
        if (stim_q.size() > 0 && (calm || $urandom_range(0, 99) >= 23)) begin
          cur_item = stim_q.pop_front();
          char_word <= cur_item.w;
          char_valid <= 1'b1;
        end else begin
          char_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each output word, stalls at random, holds off once for a long stretch.
  always @(posedge clk) begin
    if (!rst) begin
      if (tok_valid && !tok_stall) begin
        n_checked++;
        if (token_q.size() == 0) begin
          $error("unexpected output word %h", tok_word);
          n_fail++;
        end else begin
          want = token_q.pop_front();
          if (tok_word.stream_kind !== want.stream_kind) begin
            $error("stream_kind: expected %0d, got %0d", want.stream_kind, tok_word.stream_kind);
            n_fail++;
          end
          if (tok_word.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d", want.out_value, tok_word.out_value);
            n_fail++;
          end
          if (tok_word.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run, tok_word.last_of_run);
            n_fail++;
          end
          if (tok_word.overflow_flag !== want.overflow_flag) begin
            $error("overflow_flag: expected %0d, got %0d",
                   want.overflow_flag, tok_word.overflow_flag);
            n_fail++;
          end
        end
      end
      if (!hold_done && n_taken >= 30) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        tok_stall <= 1'b1;
      end else begin
        tok_stall <= !calm && ($urandom_range(0, 99) < 23);
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (tok_valid && !tok_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    char_valid = 1'b0;
    char_word = '0;
    tok_stall = 1'b0;
    for (int i = 0; i < N_DIRECTED; i++) stim_q.push_back(DIRECTED[i]);
    build_random();
    n_total = stim_q.size();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (n_taken == n_total);
    wait (token_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run: %0d input words (%0d directed), %0d output words checked",
             n_total, N_DIRECTED, n_checked);
    $display("Seen: %0d word flushes, %0d keyword tokens, %0d characters dropped on a full hopper",
             n_flush, n_kw, n_drop);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
